FILE: rtl/morph_erode_dilate_window_top_defines.svh
// Assertion helpers for the block's top module.
// Each expects clk and rst_n in the scope where it is used.
`ifndef MORPH_ERODE_DILATE_WINDOW_TOP_DEFINES_SVH
`define MORPH_ERODE_DILATE_WINDOW_TOP_DEFINES_SVH

// Same-cycle implication.
`define MED_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MED_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/med_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package med_pkg;

    localparam int WIN_SIZE   = 5;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_BITS   = 8;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = COL_W + 1;
    localparam int HGT_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int OUT_ROW_W  = HGT_W;
    localparam int IN_ROW_W   = HGT_W + 1;
    localparam int ORG_W      = 3;
    localparam int MODE_W     = 2;
    localparam int MASK_W     = WIN_SIZE * WIN_SIZE;
    localparam int DLY_W      = $clog2((WIN_SIZE - 1) * MAX_WIDTH + WIN_SIZE);
    localparam int STACK_W    = (WIN_SIZE - 1) * PIX_BITS;
    localparam int OFF_W      = $clog2(2 * WIN_SIZE - 1);
    localparam int TRB_W      = HGT_W + 1;
    localparam int TCB_W      = WID_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = MASK_W;

    localparam int OUT_DEPTH  = 8;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OCC_W      = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_ROW = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_COL = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = CFG_IDX_W'(5);

    localparam logic [MODE_W-1:0] MODE_BERODE = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_GERODE = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_DILATE = MODE_W'(2);

    localparam logic [MODE_W-1:0] RST_MODE   = MODE_BERODE;
    localparam logic [MASK_W-1:0] RST_MASK   = MASK_W'(4657152);
    localparam logic [ORG_W-1:0]  RST_ORG    = ORG_W'(2);
    localparam logic [WID_W-1:0]  RST_WIDTH  = WID_W'(640);
    localparam logic [HGT_W-1:0]  RST_HEIGHT = HGT_W'(480);

    typedef logic [PIX_BITS-1:0] pix_t;

    localparam pix_t PIX_ONE = PIX_BITS'(1);

    typedef logic [WIN_SIZE-1:0][PIX_BITS-1:0] med_col_t;

    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [OUT_ROW_W-1:0] out_r;
        logic [COL_W-1:0]     out_c;
    } med_meta_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MASK_W-1:0] se_mask;
        logic [ORG_W-1:0]  orow;
        logic [ORG_W-1:0]  ocol;
        logic [WID_W-1:0]  eff_w;
        logic [HGT_W-1:0]  eff_h;
    } med_cfg_t;

    typedef struct packed {
        logic last;
        pix_t pix;
    } med_res_t;

endpackage

`default_nettype wire

FILE: rtl/med_lbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module med_lbuf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_en,
    input  logic [med_pkg::COL_W-1:0] in_col,
    input  med_pkg::pix_t            in_pix,
    input  med_pkg::med_meta_t       in_meta,
    output logic                     col_valid,
    output med_pkg::med_col_t        col_pix,
    output med_pkg::med_meta_t       col_meta
);
    import med_pkg::*;

    logic [STACK_W-1:0] mem [MAX_WIDTH];
    logic [STACK_W-1:0] rd_data_reg;
    logic [STACK_W-1:0] fwd_data_reg;
    logic [STACK_W-1:0] stack;
    logic [STACK_W-1:0] wr_data;
    logic               fwd_hit_reg;
    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    pix_t               s1_pix_reg;
    med_meta_t          s1_meta_reg;

    always_ff @(posedge clk)
    begin
        if (in_en)
        begin
            rd_data_reg <= mem[in_col];
        end
        if (s1_valid_reg)
        begin
            mem[s1_col_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en)
        begin
            s1_col_reg   <= in_col;
            s1_pix_reg   <= in_pix;
            s1_meta_reg  <= in_meta;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_en;
            fwd_hit_reg  <= in_en && s1_valid_reg && (s1_col_reg == in_col);
        end
    end

    // take the column stack being written this cycle when it is read back at once
    assign stack   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data = {stack[(WIN_SIZE-2)*PIX_BITS-1:0], s1_pix_reg};

    always_comb
    begin
        col_pix[0] = s1_pix_reg;
        for (int k = 1; k < WIN_SIZE; k++)
        begin
            col_pix[k] = stack[(k-1)*PIX_BITS +: PIX_BITS];
        end
    end

    assign col_valid = s1_valid_reg;
    assign col_meta  = s1_meta_reg;

endmodule

`default_nettype wire

FILE: rtl/med_win.sv
`timescale 1ns / 1ps
`default_nettype none

module med_win (
    input  logic               clk,
    input  logic               rst_n,
    input  med_pkg::med_cfg_t  cfg,
    input  logic               col_valid,
    input  med_pkg::med_col_t  col_pix,
    input  med_pkg::med_meta_t col_meta,
    output logic               res_valid,
    output med_pkg::med_res_t  res
);
    import med_pkg::*;

    pix_t                win_reg [WIN_SIZE][WIN_SIZE];
    med_meta_t           s2_meta_reg;
    logic                s2_valid_reg;
    logic                dil;
    logic [WIN_SIZE-1:0] row_ok;
    logic [WIN_SIZE-1:0] col_ok;
    pix_t                rmin [WIN_SIZE];
    logic [WIN_SIZE-1:0] rone;
    logic [WIN_SIZE-1:0] rzero;
    pix_t                centre;

    logic                s3_valid_reg;
    logic                s3_last_reg;
    pix_t                rmin_reg [WIN_SIZE];
    logic [WIN_SIZE-1:0] rone_reg;
    logic [WIN_SIZE-1:0] rzero_reg;
    pix_t                centre_reg;
    pix_t                minv;
    pix_t                res_pix;

    assign dil = (cfg.mode >= MODE_DILATE);

    // shift in the newest column
    always_ff @(posedge clk)
    begin
        if (col_valid)
        begin
            for (int k = 0; k < WIN_SIZE; k++)
            begin
                win_reg[k][0] <= col_pix[k];
                for (int j = 1; j < WIN_SIZE; j++)
                begin
                    win_reg[k][j] <= win_reg[k][j-1];
                end
            end
            s2_meta_reg <= col_meta;
        end
    end

    always_comb
    begin : p_border
        logic [OFF_W-1:0] roff;
        logic [OFF_W-1:0] coff;
        logic [TRB_W-1:0] trow;
        logic [TCB_W-1:0] tcol;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            roff = dil ? OFF_W'(WIN_SIZE - 1 + int'(cfg.orow) - i)
                       : OFF_W'(WIN_SIZE - 1 - int'(cfg.orow) + i);
            coff = dil ? OFF_W'(WIN_SIZE - 1 + int'(cfg.ocol) - i)
                       : OFF_W'(WIN_SIZE - 1 - int'(cfg.ocol) + i);
            trow = TRB_W'(s2_meta_reg.out_r) + TRB_W'(roff);
            tcol = TCB_W'(s2_meta_reg.out_c) + TCB_W'(coff);
            row_ok[i] = (trow >= TRB_W'(WIN_SIZE - 1))
                     && (trow < TRB_W'(cfg.eff_h) + TRB_W'(WIN_SIZE - 1));
            col_ok[i] = (tcol >= TCB_W'(WIN_SIZE - 1))
                     && (tcol < TCB_W'(cfg.eff_w) + TCB_W'(WIN_SIZE - 1));
        end
    end

    always_comb
    begin : p_reduce
        pix_t v;
        centre = '0;
        for (int mr = 0; mr < WIN_SIZE; mr++)
        begin
            rmin[mr]  = '1;
            rone[mr]  = 1'b0;
            rzero[mr] = 1'b0;
            for (int mc = 0; mc < WIN_SIZE; mc++)
            begin
                v = dil ? win_reg[mr][mc] : win_reg[WIN_SIZE-1-mr][WIN_SIZE-1-mc];
                if (!(row_ok[mr] && col_ok[mc]))
                begin
                    v = '0;
                end
                if (mr == int'(cfg.orow) && mc == int'(cfg.ocol))
                begin
                    centre = v;
                end
                if (cfg.se_mask[mr*WIN_SIZE + mc])
                begin
                    if (v == PIX_ONE)
                    begin
                        rone[mr] = 1'b1;
                    end
                    if (v == '0)
                    begin
                        rzero[mr] = 1'b1;
                    end
                    if (v < rmin[mr])
                    begin
                        rmin[mr] = v;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_last_reg <= s2_meta_reg.last;
            rmin_reg    <= rmin;
            rone_reg    <= rone;
            rzero_reg   <= rzero;
            centre_reg  <= centre;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= col_valid && col_meta.emit;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_comb
    begin
        minv = centre_reg;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            if (rmin_reg[i] < minv)
            begin
                minv = rmin_reg[i];
            end
        end
    end

    always_comb
    begin
        unique case (cfg.mode)
            MODE_BERODE: res_pix = (centre_reg == PIX_ONE && !(|rzero_reg)) ? PIX_ONE : '0;
            MODE_GERODE: res_pix = minv;
            default:     res_pix = (|rone_reg) ? PIX_ONE : '0;
        endcase
    end

    assign res_valid = s3_valid_reg;
    assign res.last  = s3_last_reg;
    assign res.pix   = res_pix;

endmodule

`default_nettype wire

FILE: rtl/med_ofifo.sv
`timescale 1ns / 1ps
`default_nettype none

module med_ofifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  med_pkg::med_res_t push_data,
    input  logic              pop,
    output logic              pop_valid,
    output med_pkg::med_res_t pop_data
);
    import med_pkg::*;

    med_res_t             fifo_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OCC_W-1:0]     cnt_reg;
    logic [OCC_W-1:0]     cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign cnt_next = cnt_reg + OCC_W'(push) - OCC_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = fifo_mem[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: rtl/morph_erode_dilate_window_top.sv
// Streaming 5x5 binary/grayscale erosion and binary dilation.
// Input channel: in_valid / in_stall carry pixel_in and pad_item in raster
// order; a transfer happens on a rising edge with in_valid high and in_stall
// low. Pad items after the last real pixel flush the final rows.
// Output channel: out_valid / out_stall carry pixel_out and frame_last, one
// result per image position in raster order, frame_last on the last one.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per edge;
// any valid write restarts the frame. Write only while the block is idle.
// Throughput: one input item per cycle while in_stall is low. A result comes
// out once its window is complete, i.e. on the item that is the look-ahead
// (rows times width plus columns) after its own position; from that transfer
// it goes through the column-stack RAM read on that edge, then the window
// shift, the min/any reduction and the output queue write.
// The line RAM holds one 32-bit column stack per image column and is read,
// shifted and written back once per item.
// Stall: results wait in an 8-entry output queue; in_stall rises once eight
// results are owed, so a stalled receiver holds the input side too.
// Reset: registers take their defaults, positions return to zero; the RAM
// needs no clearing, since border positions are masked to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "morph_erode_dilate_window_top_defines.svh"

module morph_erode_dilate_window_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [med_pkg::PIX_BITS-1:0]   pixel_in,
    input  logic                          pad_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [med_pkg::PIX_BITS-1:0]   pixel_out,
    output logic                          frame_last,
    input  logic                          cfg_wr_en,
    input  logic [med_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [med_pkg::CFG_DATA_W-1:0] cfg_data
);
    import med_pkg::*;

    logic [MODE_W-1:0]    mode_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [ORG_W-1:0]     org_row_reg;
    logic [ORG_W-1:0]     org_col_reg;
    logic [WID_W-1:0]     width_reg;
    logic [HGT_W-1:0]     height_reg;

    logic [WID_W-1:0]     eff_w;
    logic [HGT_W-1:0]     eff_h;
    logic [ORG_W-1:0]     orow;
    logic [ORG_W-1:0]     ocol;
    logic                 dil;
    logic [ORG_W-1:0]     lr;
    logic [ORG_W-1:0]     lc;
    logic [DLY_W-1:0]     delay;

    logic [COL_W-1:0]     in_col_reg,  in_col_next;
    logic [IN_ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [DLY_W-1:0]     lead_reg,    lead_next;
    logic [OUT_ROW_W-1:0] out_r_reg,   out_r_next;
    logic [COL_W-1:0]     out_c_reg,   out_c_next;
    logic [OCC_W-1:0]     occ_reg,     occ_next;

    logic                 cfg_hit;
    logic                 acc;
    logic                 in_image;
    logic                 ignore;
    logic                 adv;
    logic                 emit;
    logic                 emit_last;
    logic                 out_xfer;

    med_meta_t            meta;
    med_cfg_t             cfg;
    logic                 col_valid;
    med_col_t             col_pix;
    med_meta_t            col_meta;
    logic                 res_valid;
    med_res_t             res;
    med_res_t             fifo_out;

    assign cfg_hit = cfg_wr_en && (cfg_index <= CFG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= RST_MODE;
            mask_reg    <= RST_MASK;
            org_row_reg <= RST_ORG;
            org_col_reg <= RST_ORG;
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MODE:    mode_reg    <= cfg_data[MODE_W-1:0];
                CFG_MASK:    mask_reg    <= cfg_data[MASK_W-1:0];
                CFG_ORG_ROW: org_row_reg <= cfg_data[ORG_W-1:0];
                CFG_ORG_COL: org_col_reg <= cfg_data[ORG_W-1:0];
                CFG_WIDTH:   width_reg   <= cfg_data[WID_W-1:0];
                CFG_HEIGHT:  height_reg  <= cfg_data[HGT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg == '0)
        begin
            eff_w = WID_W'(1);
        end
        else if (width_reg > WID_W'(MAX_WIDTH))
        begin
            eff_w = WID_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
    end

    assign eff_h = (height_reg == '0) ? HGT_W'(1) : height_reg;
    assign orow  = (org_row_reg > ORG_W'(WIN_SIZE - 1)) ? ORG_W'(WIN_SIZE - 1) : org_row_reg;
    assign ocol  = (org_col_reg > ORG_W'(WIN_SIZE - 1)) ? ORG_W'(WIN_SIZE - 1) : org_col_reg;
    assign dil   = (mode_reg >= MODE_DILATE);
    assign lr    = dil ? orow : ORG_W'(WIN_SIZE - 1) - orow;
    assign lc    = dil ? ocol : ORG_W'(WIN_SIZE - 1) - ocol;
    assign delay = DLY_W'(lr) * DLY_W'(eff_w) + DLY_W'(lc);

    assign acc       = in_valid && !in_stall;
    assign in_image  = (in_row_reg < eff_h);
    assign ignore    = in_image && pad_item;
    assign adv       = acc && !ignore;
    assign emit      = adv && (lead_reg == delay);
    assign emit_last = emit && (out_r_reg == OUT_ROW_W'(eff_h - 1'b1))
                            && (out_c_reg == COL_W'(eff_w - 1'b1));
    assign out_xfer  = out_valid && !out_stall;

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        lead_next   = lead_reg;
        out_r_next  = out_r_reg;
        out_c_next  = out_c_reg;
        priority if (cfg_hit || emit_last)
        begin
            in_col_next = '0;
            in_row_next = '0;
            lead_next   = '0;
            out_r_next  = '0;
            out_c_next  = '0;
        end
        else
        begin
            if (adv)
            begin
                if (in_col_reg == COL_W'(eff_w - 1'b1))
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
                if (lead_reg != delay)
                begin
                    lead_next = lead_reg + 1'b1;
                end
            end
            if (emit)
            begin
                if (out_c_reg == COL_W'(eff_w - 1'b1))
                begin
                    out_c_next = '0;
                    out_r_next = out_r_reg + 1'b1;
                end
                else
                begin
                    out_c_next = out_c_reg + 1'b1;
                end
            end
        end
    end

    assign occ_next = occ_reg + OCC_W'(emit) - OCC_W'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            lead_reg   <= '0;
            out_r_reg  <= '0;
            out_c_reg  <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            lead_reg   <= lead_next;
            out_r_reg  <= out_r_next;
            out_c_reg  <= out_c_next;
            occ_reg    <= occ_next;
        end
    end

    // hold the input once every queue slot is owed a result
    assign in_stall = (occ_reg == OCC_W'(OUT_DEPTH));

    always_comb
    begin
        meta.emit  = emit;
        meta.last  = emit_last;
        meta.out_r = out_r_reg;
        meta.out_c = out_c_reg;
        cfg.mode    = mode_reg;
        cfg.se_mask = mask_reg;
        cfg.orow    = orow;
        cfg.ocol    = ocol;
        cfg.eff_w   = eff_w;
        cfg.eff_h   = eff_h;
    end

    med_lbuf u_lbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_en     (adv),
        .in_col    (in_col_reg),
        .in_pix    (pixel_in),
        .in_meta   (meta),
        .col_valid (col_valid),
        .col_pix   (col_pix),
        .col_meta  (col_meta)
    );

    med_win u_win (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .col_valid (col_valid),
        .col_pix   (col_pix),
        .col_meta  (col_meta),
        .res_valid (res_valid),
        .res       (res)
    );

    med_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (out_xfer),
        .pop_valid (out_valid),
        .pop_data  (fifo_out)
    );

    assign pixel_out  = fifo_out.pix;
    assign frame_last = fifo_out.last;

    `MED_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= OCC_W'(OUT_DEPTH), "result credit overflow")
    `MED_ASSERT_NOW(a_out_owed, out_valid, occ_reg != '0, "output valid with no result owed")
    `MED_ASSERT_NOW(a_lead_bound, 1'b1, lead_reg <= delay, "look-ahead counter past delay")
    `MED_ASSERT_NEXT(a_frame_wrap, emit_last,
        in_col_reg == '0 && in_row_reg == '0 && lead_reg == '0 && out_r_reg == '0,
        "positions not cleared after frame end")
    `MED_ASSERT_NEXT(a_pad_hold, acc && ignore && !cfg_hit,
        $stable(in_col_reg) && $stable(in_row_reg) && $stable(lead_reg),
        "early pad item moved the input position")

endmodule

`default_nettype wire
